// ----- design/dcr_pkg.sv -----
// ----------------------------------------------------------------------------
// Diversity combining receiver package
// Item types, lane result types and combiner codes shared by the design.
// ----------------------------------------------------------------------------
package dcr_pkg;

  localparam int SAMPLE_W = 12;
  localparam int BYTE_W   = 8;
  localparam int TECH_W   = 2;
  localparam int LANES    = 3;

  localparam logic [TECH_W-1:0] TECH_EGC = 2'd0;
  localparam logic [TECH_W-1:0] TECH_MLC = 2'd1;
  localparam logic [TECH_W-1:0] TECH_SEL = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_r1;
    logic [SAMPLE_W-1:0] sample_r2;
    logic [SAMPLE_W-1:0] sample_r3;
  } sample_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic [TECH_W-1:0]   technique;
    logic [SAMPLE_W-1:0] threshold_level;
  } result_t;

  typedef struct packed {
    logic ge;
    logic gt;
  } lane_t;

  typedef struct packed {
    logic                egc_bit;
    logic                mlc_bit;
    logic [SAMPLE_W-1:0] max_val;
  } merge_t;

endpackage

// ----- design/dcr_lane.sv -----
// ----------------------------------------------------------------------------
// Diversity combining receiver lane
// Slices one receiver's sample against the decision threshold.
// ----------------------------------------------------------------------------
module dcr_lane (
  input  logic [dcr_pkg::SAMPLE_W-1:0] sample,
  input  logic [dcr_pkg::SAMPLE_W-1:0] threshold,
  output dcr_pkg::lane_t               decision
);

  assign decision.ge = sample >= threshold;
  assign decision.gt = sample > threshold;

endmodule

// ----- design/dcr_merge.sv -----
// ----------------------------------------------------------------------------
// Diversity combining receiver merge stage
// Forms the equal-gain bit from the sample sum and the majority bit from the
// lane decisions, and finds the largest sample of the item.
// ----------------------------------------------------------------------------
module dcr_merge (
  input  dcr_pkg::sample_t                          samples,
  input  dcr_pkg::lane_t [dcr_pkg::LANES-1:0]       lanes,
  input  logic [dcr_pkg::SAMPLE_W-1:0]              threshold,
  output dcr_pkg::merge_t                           merged
);

  localparam int SUM_W = dcr_pkg::SAMPLE_W + 2;

  logic [SUM_W-1:0]             sum;
  logic [SUM_W-1:0]             thr3;
  logic [dcr_pkg::SAMPLE_W-1:0] max12;

  // The truncated average reaches the threshold exactly when the sum
  // reaches three times the threshold.
  assign sum  = SUM_W'(samples.sample_r1) + SUM_W'(samples.sample_r2)
              + SUM_W'(samples.sample_r3);
  assign thr3 = {1'b0, threshold, 1'b0} + SUM_W'(threshold);

  always_comb begin
    max12 = samples.sample_r1;
    if (samples.sample_r2 > max12) max12 = samples.sample_r2;
    if (samples.sample_r3 > max12) max12 = samples.sample_r3;
  end

  assign merged.egc_bit = sum >= thr3;
  assign merged.mlc_bit = (lanes[0].ge & lanes[1].ge) | (lanes[0].ge & lanes[2].ge)
                        | (lanes[1].ge & lanes[2].ge);
  assign merged.max_val = max12;

endmodule

// ----- design/diversity_combining_receiver.sv -----
// ----------------------------------------------------------------------------
// Three-branch diversity combining receiver
// Calibrates a threshold, trains to pick a combiner (recalibrating if none wins),
// then decodes one byte.
// A byte appears in the output register in the cycle after the last
// decoding item is accepted.
// Throughput: one item per cycle unless sample_stall holds; per-item slicing,
// the combiner merge and the threshold reciprocal multiply are combinational.
// Reset: synchronous rst returns the block to calibration with all counts,
// the threshold and the output register cleared.
module diversity_combining_receiver #(
  parameter int BITS_PER_PHASE = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  dcr_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output dcr_pkg::result_t result
);

  localparam int IW    = (BITS_PER_PHASE > 1) ? $clog2(BITS_PER_PHASE) : 1;
  localparam int CW    = $clog2(BITS_PER_PHASE + 1);
  localparam int SW    = dcr_pkg::SAMPLE_W + $clog2(BITS_PER_PHASE);
  localparam int SHIFT = SW + $clog2(BITS_PER_PHASE);
  localparam int RW    = SHIFT + 1;
  localparam int PW    = SW + RW;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + BITS_PER_PHASE - 1) / BITS_PER_PHASE;
  localparam logic [IW-1:0] LAST_IDX = IW'(BITS_PER_PHASE - 1);

  localparam logic [1:0] PH_CAL    = 2'd0;
  localparam logic [1:0] PH_TRAIN  = 2'd1;
  localparam logic [1:0] PH_DECODE = 2'd2;

  logic [1:0]                   phase;
  logic [IW-1:0]                bit_index;
  logic [SW-1:0]                max_sum;
  logic [dcr_pkg::SAMPLE_W-1:0] threshold;
  logic [CW-1:0]                egc_ones;
  logic [CW-1:0]                mlc_ones;
  logic [CW-1:0]                branch_ones [dcr_pkg::LANES];
  logic [dcr_pkg::TECH_W-1:0]   chosen_technique;
  logic [1:0]                   best_branch;
  logic [dcr_pkg::BYTE_W-1:0]   shift_byte;

  dcr_pkg::lane_t [dcr_pkg::LANES-1:0] lanes;
  dcr_pkg::merge_t                     merged;
  logic [dcr_pkg::SAMPLE_W-1:0]        lane_samples [dcr_pkg::LANES];

  logic                         accept;
  logic                         last;
  logic [SW-1:0]                max_sum_next;
  logic [PW-1:0]                product;
  logic [dcr_pkg::SAMPLE_W-1:0] threshold_next;
  logic [CW-1:0]                egc_next;
  logic [CW-1:0]                mlc_next;
  logic [CW-1:0]                branch_next [dcr_pkg::LANES];
  logic [1:0]                   best_next;
  logic [CW-1:0]                sel_count;
  logic                         decode_bit;
  logic [dcr_pkg::BYTE_W-1:0]   shift_byte_next;

  assign lane_samples[0] = sample.sample_r1;
  assign lane_samples[1] = sample.sample_r2;
  assign lane_samples[2] = sample.sample_r3;

  for (genvar g = 0; g < dcr_pkg::LANES; g++) begin : g_lane
    dcr_lane u_lane (
      .sample    (lane_samples[g]),
      .threshold (threshold),
      .decision  (lanes[g])
    );
  end

  dcr_merge u_merge (
    .samples   (sample),
    .lanes     (lanes),
    .threshold (threshold),
    .merged    (merged)
  );

  assign last         = bit_index == LAST_IDX;
  assign sample_stall = result_valid & result_stall & (phase == PH_DECODE) & last;
  assign accept       = sample_valid & ~sample_stall;

  // Threshold is the truncated average, taken by a reciprocal multiply.
  assign max_sum_next   = max_sum + SW'(merged.max_val);
  assign product        = PW'(max_sum_next) * PW'(RW'(RECIP));
  assign threshold_next = product[SHIFT +: dcr_pkg::SAMPLE_W];

  assign egc_next = egc_ones + CW'(merged.egc_bit);
  assign mlc_next = mlc_ones + CW'(merged.mlc_bit);

  always_comb begin
    for (int i = 0; i < dcr_pkg::LANES; i++) begin
      branch_next[i] = branch_ones[i] + CW'(lanes[i].ge);
    end
    best_next = 2'd0;
    sel_count = branch_next[0];
    if (branch_next[1] > sel_count) begin
      best_next = 2'd1;
      sel_count = branch_next[1];
    end
    if (branch_next[2] > sel_count) begin
      best_next = 2'd2;
      sel_count = branch_next[2];
    end
  end

  always_comb begin
    case (chosen_technique)
      dcr_pkg::TECH_EGC: decode_bit = merged.egc_bit;
      dcr_pkg::TECH_MLC: decode_bit = merged.mlc_bit;
      default: begin
        case (best_branch)
          2'd0:    decode_bit = lanes[0].gt;
          2'd1:    decode_bit = lanes[1].gt;
          default: decode_bit = lanes[2].gt;
        endcase
      end
    endcase
  end

  assign shift_byte_next = {shift_byte[dcr_pkg::BYTE_W-2:0], decode_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_CAL;
      bit_index        <= '0;
      max_sum          <= '0;
      threshold        <= '0;
      egc_ones         <= '0;
      mlc_ones         <= '0;
      for (int i = 0; i < dcr_pkg::LANES; i++) branch_ones[i] <= '0;
      chosen_technique <= dcr_pkg::TECH_EGC;
      best_branch      <= '0;
      shift_byte       <= '0;
      result_valid     <= 1'b0;
      result           <= '0;
    end else begin
      if (accept && phase == PH_DECODE && last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        bit_index <= last ? '0 : bit_index + IW'(1);
        unique case (phase)
          PH_TRAIN: begin
            if (last) begin
              best_branch <= best_next;
              egc_ones    <= '0;
              mlc_ones    <= '0;
              for (int i = 0; i < dcr_pkg::LANES; i++) branch_ones[i] <= '0;
              shift_byte  <= '0;
              if (egc_next > mlc_next && egc_next > sel_count) begin
                chosen_technique <= dcr_pkg::TECH_EGC;
                phase            <= PH_DECODE;
              end else if (mlc_next > egc_next && mlc_next > sel_count) begin
                chosen_technique <= dcr_pkg::TECH_MLC;
                phase            <= PH_DECODE;
              end else if (sel_count > egc_next && sel_count > mlc_next) begin
                chosen_technique <= dcr_pkg::TECH_SEL;
                phase            <= PH_DECODE;
              end else begin
                phase   <= PH_CAL;
                max_sum <= '0;
              end
            end else begin
              egc_ones <= egc_next;
              mlc_ones <= mlc_next;
              for (int i = 0; i < dcr_pkg::LANES; i++) branch_ones[i] <= branch_next[i];
            end
          end
          PH_DECODE: begin
            if (last) begin
              result.data_byte       <= shift_byte_next;
              result.technique       <= chosen_technique;
              result.threshold_level <= threshold;
              shift_byte             <= '0;
              max_sum                <= '0;
              phase                  <= PH_CAL;
            end else begin
              shift_byte <= shift_byte_next;
            end
          end
          default: begin
            if (last) begin
              threshold <= threshold_next;
              max_sum   <= '0;
              egc_ones  <= '0;
              mlc_ones  <= '0;
              for (int i = 0; i < dcr_pkg::LANES; i++) branch_ones[i] <= '0;
              phase     <= PH_TRAIN;
            end else begin
              max_sum <= max_sum_next;
              phase   <= PH_CAL;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Diversity combining receiver testbench
// Sends three-receiver sample items in calibrate, train and decode frames,
// predicts every decoded byte from an independent model of the block and
// checks each one field by field under random sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BITS      = 8;
  localparam int IDLE_MAX  = 2000;
  localparam int FULL      = 4095;

  typedef enum logic [1:0] {PH_CAL, PH_TRAIN, PH_DECODE} phase_e;

  class combiner_model;
    phase_e           phase = PH_CAL;
    int               bit_index = 0;
    int               max_sum = 0;
    logic [11:0]      threshold = '0;
    int               egc_ones = 0;
    int               mlc_ones = 0;
    int               lane_ones[3] = '{0, 0, 0};
    logic [1:0]       technique = dcr_pkg::TECH_EGC;
    int               best_lane = 0;
    logic [7:0]       shift_byte = '0;
    dcr_pkg::result_t expected_bytes[$];
    int               mismatches = 0;
    int               samples_seen = 0;
    int               dropped_frames = 0;
    int               bytes_by_tech[3] = '{0, 0, 0};

    task report(string msg);
      $display("ERROR at %0d ns: %s", $time, msg);
      mismatches++;
    endtask

    function void clear_counts();
      egc_ones = 0;
      mlc_ones = 0;
      lane_ones = '{0, 0, 0};
    endfunction

    function void note_sample(dcr_pkg::sample_t s);
      logic [11:0]      v[3];
      logic [13:0]      total;
      logic [11:0]      peak;
      int               votes;
      int               sel_ones;
      bit               egc_bit, mlc_bit, last, bit_val;
      dcr_pkg::result_t r;
      v[0] = s.sample_r1;
      v[1] = s.sample_r2;
      v[2] = s.sample_r3;
      samples_seen++;
      votes = 0;
      for (int i = 0; i < 3; i++) if (v[i] >= threshold) votes++;
      total = v[0] + v[1] + v[2];
      egc_bit = (total / 3) >= threshold;
      mlc_bit = votes >= 2;
      last = (bit_index + 1) >= BITS;
      case (phase)
        PH_TRAIN: begin
          if (egc_bit) egc_ones++;
          if (mlc_bit) mlc_ones++;
          for (int i = 0; i < 3; i++) if (v[i] >= threshold) lane_ones[i]++;
          bit_index++;
          if (last) begin
            best_lane = 0;
            if (lane_ones[1] > lane_ones[best_lane]) best_lane = 1;
            if (lane_ones[2] > lane_ones[best_lane]) best_lane = 2;
            sel_ones = lane_ones[best_lane];
            bit_index = 0;
            if (egc_ones > mlc_ones && egc_ones > sel_ones) begin
              technique = dcr_pkg::TECH_EGC;
              phase = PH_DECODE;
            end else if (mlc_ones > egc_ones && mlc_ones > sel_ones) begin
              technique = dcr_pkg::TECH_MLC;
              phase = PH_DECODE;
            end else if (sel_ones > egc_ones && sel_ones > mlc_ones) begin
              technique = dcr_pkg::TECH_SEL;
              phase = PH_DECODE;
            end else begin
              phase = PH_CAL;
              max_sum = 0;
              dropped_frames++;
            end
            clear_counts();
            shift_byte = '0;
          end
        end
        PH_DECODE: begin
          if (technique == dcr_pkg::TECH_EGC) begin
            bit_val = egc_bit;
          end else if (technique == dcr_pkg::TECH_MLC) begin
            bit_val = mlc_bit;
          end else begin
            bit_val = v[best_lane] > threshold;
          end
          shift_byte = {shift_byte[6:0], bit_val};
          bit_index++;
          if (last) begin
            r.data_byte = shift_byte;
            r.technique = technique;
            r.threshold_level = threshold;
            expected_bytes.push_back(r);
            bytes_by_tech[technique]++;
            shift_byte = '0;
            bit_index = 0;
            max_sum = 0;
            phase = PH_CAL;
          end
        end
        default: begin
          peak = v[0];
          if (v[1] > peak) peak = v[1];
          if (v[2] > peak) peak = v[2];
          max_sum += peak;
          bit_index++;
          phase = PH_CAL;
          if (last) begin
            threshold = 12'(max_sum / BITS);
            max_sum = 0;
            bit_index = 0;
            clear_counts();
            phase = PH_TRAIN;
          end
        end
      endcase
    endfunction

    task check_byte(dcr_pkg::result_t got);
      dcr_pkg::result_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %h", got));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
      if (got.technique !== want.technique)
        report($sformatf("technique %0d, expected %0d", got.technique, want.technique));
      if (got.threshold_level !== want.threshold_level)
        report($sformatf("threshold_level %0d, expected %0d",
                         got.threshold_level, want.threshold_level));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             sample_valid;
  logic             sample_stall;
  dcr_pkg::sample_t sample;
  logic             result_valid;
  logic             result_stall;
  dcr_pkg::result_t result;

  combiner_model sb = new();
  int          send_idle_pct = 24;
  int          recv_idle_pct = 80;
  int          idle_cycles = 0;
  int          cal_mode = 0;
  bit          train_noise = 1'b0;
  logic [1:0]  train_goal = dcr_pkg::TECH_EGC;
  int          sel_lane = 0;

  diversity_combining_receiver #(.BITS_PER_PHASE(BITS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic dcr_pkg::sample_t mk(int a, int b, int c);
    dcr_pkg::sample_t s;
    s.sample_r1 = 12'((a < 0) ? 0 : (a > FULL) ? FULL : a);
    s.sample_r2 = 12'((b < 0) ? 0 : (b > FULL) ? FULL : b);
    s.sample_r3 = 12'((c < 0) ? 0 : (c > FULL) ? FULL : c);
    return s;
  endfunction

  function automatic int level(int t);
    case ($urandom_range(5))
      0: return 0;
      1: return FULL;
      2: return t - 1;
      3: return t;
      4: return t + 1;
      default: return $urandom_range(FULL);
    endcase
  endfunction

  task automatic send_item(input dcr_pkg::sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall !== 1'b0);
    sb.note_sample(s);
  endtask

  task automatic next_item(output dcr_pkg::sample_t s);
    int t;
    int hot;
    int lo[3];
    t = sb.threshold;
    hot = sb.bit_index % 3;
    case (sb.phase)
      PH_TRAIN: begin
        if (sb.bit_index == 0) begin
          train_noise = $urandom_range(9) >= 8;
          train_goal = 2'($urandom_range(2));
          sel_lane = $urandom_range(2);
        end
        if (train_noise) begin
          s = mk(level(t), level(t), level(t));
        end else begin
          case (train_goal)
            dcr_pkg::TECH_EGC: begin
              for (int i = 0; i < 3; i++) lo[i] = (i == hot) ? FULL : t - 1;
            end
            dcr_pkg::TECH_MLC: begin
              for (int i = 0; i < 3; i++) lo[i] = (i == hot) ? 0 : t;
            end
            default: begin
              for (int i = 0; i < 3; i++)
                lo[i] = (i == sel_lane) ? t : (t > 0) ? $urandom_range(t - 1) : 0;
            end
          endcase
          s = mk(lo[0], lo[1], lo[2]);
        end
      end
      PH_DECODE: s = mk(level(t), level(t), level(t));
      default: begin
        if (sb.bit_index == 0) cal_mode = $urandom_range(9);
        case (cal_mode)
          0: s = mk(0, 0, 0);
          1: s = mk(FULL, FULL, FULL);
          2: s = mk($urandom_range(600), $urandom_range(600), $urandom_range(600));
          default: s = mk($urandom_range(FULL), $urandom_range(FULL), $urandom_range(FULL));
        endcase
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) sb.check_byte(result);
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_MAX) begin
        $display("Timeout: no item accepted for %0d cycles.", IDLE_MAX);
        $display("diversity_combining_receiver: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [11:0]      t;
    dcr_pkg::sample_t s;
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Calibration with both extremes and each receiver holding the maximum.
    send_item(mk(0, 0, 0));
    send_item(mk(FULL, FULL, FULL));
    send_item(mk(FULL, 0, 0));
    send_item(mk(0, FULL, 0));
    send_item(mk(0, 0, FULL));
    repeat (3) send_item(mk(0, 0, 0));
    t = sb.threshold;
    // Receivers one and two tie in training, so selection on receiver one wins.
    for (int i = 0; i < 8; i++) send_item((i % 2) ? mk(0, t, 0) : mk(t, 0, 0));
    // Selection needs a sample strictly above the threshold.
    send_item(mk(t, FULL, FULL));
    send_item(mk(t + 1, 0, 0));
    send_item(mk(FULL, 0, 0));
    send_item(mk(0, FULL, FULL));
    repeat (4) send_item(mk(level(t), level(t), level(t)));

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 80 : 0;
      recv_idle_pct = (mode == 0) ? 80 : (mode == 1) ? 24 : 0;
      repeat (500) begin
        next_item(s);
        send_item(s);
      end
    end
    sample_valid <= 1'b0;

    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    while (sb.expected_bytes.size() != 0) begin
      void'(sb.expected_bytes.pop_front());
      sb.report("expected byte never arrived");
    end

    $display("Sent %0d items; bytes by combiner: equal gain %0d, majority %0d, selection %0d.",
             sb.samples_seen, sb.bytes_by_tech[0], sb.bytes_by_tech[1], sb.bytes_by_tech[2]);
    $display("%0d training frames had no clear winner and fell back to calibration.",
             sb.dropped_frames);
    if (sb.mismatches == 0) begin
      $display("diversity_combining_receiver: match");
    end else begin
      $display("diversity_combining_receiver: mismatch");
    end
    $finish;
  end

endmodule
